// ----- rtl/core/sprite_pixel_collision_defines.svh -----
// Assertion macros for the sprite collision block.
`ifndef SPRITE_PIXEL_COLLISION_DEFINES_SVH
`define SPRITE_PIXEL_COLLISION_DEFINES_SVH

// same-cycle implication, held off during reset
`define SPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define SPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/spc_pkg.sv -----
// Shared types and codes for the sprite collision block.
`default_nettype none
package spc_pkg;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_SIZE = 2'd1;
  localparam logic [1:0] ACT_TEST = 2'd2;

  localparam int unsigned PIX_COL_BITS = 6;
  localparam int unsigned PIX_ROW_BITS = 6;
  localparam int unsigned RGB_BITS     = 24;
  localparam int unsigned SIZE_BITS    = 7;
  localparam int unsigned ACT_BITS     = 2;

  localparam logic [7:0] CHAN_MAX = 8'd255;

  typedef struct packed {
    logic done;
    logic hit;
  } spc_status_t;

  function automatic logic spc_opaque(input logic [RGB_BITS-1:0] rgb);
    logic white;
    logic black;
    white = (rgb[23:16] == CHAN_MAX) && (rgb[15:8] == CHAN_MAX) && (rgb[7:0] == CHAN_MAX);
    black = (rgb == '0);
    return !(white || black);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/spc_mask_mem.sv -----
// One-bit opacity mask memory, one write and one registered read port.
`default_nettype none
module spc_mask_mem #(
  parameter int unsigned ADDR_BITS = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [ADDR_BITS-1:0] waddr_i,
  input  wire logic                 wdata_i,
  input  wire logic                 re_i,
  input  wire logic [ADDR_BITS-1:0] raddr_i,
  output logic                      rdata_o
);

  logic mem [2**ADDR_BITS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/spc_walk.sv -----
// Overlap geometry and mask walk sequencer for one collision test.
`default_nettype none
`include "sprite_pixel_collision_defines.svh"
module spc_walk
  import spc_pkg::*;
#(
  parameter int unsigned SIDE_BITS  = 6,
  parameter int unsigned SW         = 7,
  parameter int unsigned COORD_BITS = 11
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic                         active_i,
  input  wire logic signed [COORD_BITS-1:0] x1_i,
  input  wire logic signed [COORD_BITS-1:0] y1_i,
  input  wire logic signed [COORD_BITS-1:0] x2_i,
  input  wire logic signed [COORD_BITS-1:0] y2_i,
  input  wire logic [SW-1:0]                w1_i,
  input  wire logic [SW-1:0]                h1_i,
  input  wire logic [SW-1:0]                w2_i,
  input  wire logic [SW-1:0]                h2_i,
  output logic                              rd_en_o,
  output logic [2*SIDE_BITS-1:0]            rd_addr_a_o,
  output logic [2*SIDE_BITS-1:0]            rd_addr_b_o,
  input  wire logic                         rd_a_i,
  input  wire logic                         rd_b_i,
  output spc_status_t                       status_o
);

  localparam int unsigned CW = COORD_BITS + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_BOX   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;

  logic [2:0] state_q, state_d;
  logic signed [CW-1:0] x1_q, y1_q, x2_q, y2_q;
  logic signed [CW-1:0] e1x_q, e1y_q, e2x_q, e2y_q;
  logic signed [CW-1:0] ovw_q, ovh_q;
  logic act_q;
  logic [SIDE_BITS-1:0] acol_q, arow_q, bcol_q, brow_q;
  logic [SIDE_BITS-1:0] wlast_q, hlast_q;
  logic [SIDE_BITS-1:0] ci_q, ci_d, ri_q, ri_d;
  logic pend_q;

  logic signed [CW-1:0] lx, hx, ly, hy;
  logic signed [CW-1:0] dacol, darow, dbcol, dbrow, wm1, hm1;
  logic go, hit_now, last_issue;

  always_comb begin
    lx = (x1_q > x2_q) ? x1_q : x2_q;
    hx = (e1x_q < e2x_q) ? e1x_q : e2x_q;
    ly = (y1_q > y2_q) ? y1_q : y2_q;
    hy = (e1y_q < e2y_q) ? e1y_q : e2y_q;
    dacol = lx - x1_q;
    darow = ly - y1_q;
    dbcol = lx - x2_q;
    dbrow = ly - y2_q;
    wm1 = ovw_q - CW'(1);
    hm1 = ovh_q - CW'(1);
  end

  assign go         = act_q && (ovw_q > 0) && (ovh_q > 0);
  assign hit_now    = pend_q && rd_a_i && rd_b_i;
  assign last_issue = (ci_q == wlast_q) && (ri_q == hlast_q);

  assign rd_addr_a_o = {arow_q + ri_q, acol_q + ci_q};
  assign rd_addr_b_o = {brow_q + ri_q, bcol_q + ci_q};

  always_comb begin
    state_d       = state_q;
    ci_d          = ci_q;
    ri_d          = ri_q;
    rd_en_o       = 1'b0;
    status_o.done = 1'b0;
    status_o.hit  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_SUM;
        end
      end
      S_SUM:   state_d = S_BOX;
      S_BOX:   state_d = S_CHECK;
      S_CHECK: begin
        ci_d = '0;
        ri_d = '0;
        if (go) begin
          state_d = S_WALK;
        end else begin
          state_d       = S_IDLE;
          status_o.done = 1'b1;
        end
      end
      S_WALK: begin
        if (hit_now) begin
          state_d       = S_IDLE;
          status_o.done = 1'b1;
          status_o.hit  = 1'b1;
        end else begin
          rd_en_o = 1'b1;
          if (last_issue) begin
            state_d = S_DRAIN;
          end else if (ci_q == wlast_q) begin
            ci_d = '0;
            ri_d = ri_q + 1'b1;
          end else begin
            ci_d = ci_q + 1'b1;
          end
        end
      end
      S_DRAIN: begin
        state_d       = S_IDLE;
        status_o.done = 1'b1;
        status_o.hit  = hit_now;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      ci_q    <= '0;
      ri_q    <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= rd_en_o;
      ci_q    <= ci_d;
      ri_q    <= ri_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      act_q <= active_i;
      x1_q  <= CW'(x1_i);
      y1_q  <= CW'(y1_i);
      x2_q  <= CW'(x2_i);
      y2_q  <= CW'(y2_i);
    end
    if (state_q == S_SUM) begin
      e1x_q <= x1_q + CW'($signed({1'b0, w1_i}));
      e1y_q <= y1_q + CW'($signed({1'b0, h1_i}));
      e2x_q <= x2_q + CW'($signed({1'b0, w2_i}));
      e2y_q <= y2_q + CW'($signed({1'b0, h2_i}));
    end
    if (state_q == S_BOX) begin
      ovw_q  <= hx - lx;
      ovh_q  <= hy - ly;
      acol_q <= dacol[SIDE_BITS-1:0];
      arow_q <= darow[SIDE_BITS-1:0];
      bcol_q <= dbcol[SIDE_BITS-1:0];
      brow_q <= dbrow[SIDE_BITS-1:0];
    end
    if (state_q == S_CHECK) begin
      wlast_q <= wm1[SIDE_BITS-1:0];
      hlast_q <= hm1[SIDE_BITS-1:0];
    end
  end

  `SPC_ASSERT_IMP(a_start_idle, start_i, state_q == S_IDLE, "test started while walking")
  `SPC_ASSERT_NXT(a_done_idle, status_o.done, state_q == S_IDLE, "no return to idle after done")
  `SPC_ASSERT_IMP(a_read_walk, rd_en_o, state_q == S_WALK, "mask read outside walk")
  `SPC_ASSERT_IMP(a_drain_pend, state_q == S_DRAIN, pend_q, "drain without pending read")

endmodule
`default_nettype wire

// ----- rtl/core/sprite_pixel_collision.sv -----
// Top level of the pixel-exact sprite collision block.
// Input channel: in_valid_i / in_stall_o carry one word per item with fields
// action, image_sel, pixel_col/row/rgb, size_w/h, both sprite positions and
// both_active. Load words write one opacity bit into mask 0 or 1.
// Size words set an image's width and height (saturated to MAX_SIDE).
// Test words produce one collide word on out_valid_o / out_stall_i.
// A test passes through the sum, box and check states. With an empty overlap
// or an inactive sprite the collide word follows; else the walk reads each
// overlap pixel, up to MAX_SIDE*MAX_SIDE, ending early at the first pixel
// opaque in both masks; the single read port of each mask memory paces it.
// Loads and size words are taken every cycle while no test is running.
// The input stalls during a test, and a new test stalls while an earlier
// result is still held by a stalled receiver; loads and sizes still pass.
// Reset clears sizes to zero and the control state; mask contents are
// undefined until loaded and must be written before any test reads them.
`default_nettype none
module sprite_pixel_collision
  import spc_pkg::*;
#(
  parameter int unsigned MAX_SIDE   = 64,
  parameter int unsigned COORD_BITS = 11
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [ACT_BITS-1:0]          action_i,
  input  wire logic                         image_sel_i,
  input  wire logic [PIX_COL_BITS-1:0]      pixel_col_i,
  input  wire logic [PIX_ROW_BITS-1:0]      pixel_row_i,
  input  wire logic [RGB_BITS-1:0]          pixel_rgb_i,
  input  wire logic [SIZE_BITS-1:0]         size_w_i,
  input  wire logic [SIZE_BITS-1:0]         size_h_i,
  input  wire logic signed [COORD_BITS-1:0] first_x_i,
  input  wire logic signed [COORD_BITS-1:0] first_y_i,
  input  wire logic signed [COORD_BITS-1:0] second_x_i,
  input  wire logic signed [COORD_BITS-1:0] second_y_i,
  input  wire logic [1:0]                   both_active_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              collide_o
);

  localparam int unsigned SIDE_BITS = $clog2(MAX_SIDE);
  localparam int unsigned SW        = $clog2(MAX_SIDE + 1);
  localparam int unsigned AB        = 2 * SIDE_BITS;

  logic [SW-1:0] width_q  [2];
  logic [SW-1:0] height_q [2];
  logic busy_q, out_valid_q, collide_q;

  logic accept, load_ok, we_a, we_b, opaque, start;
  logic [AB-1:0] waddr;
  logic [SW-1:0] w_clamp, h_clamp;
  logic rd_en, rd_a, rd_b;
  logic [AB-1:0] rd_addr_a, rd_addr_b;
  spc_status_t status;

  assign in_stall_o = busy_q ||
                      (out_valid_q && out_stall_i && (action_i == ACT_TEST));
  assign accept     = in_valid_i && !in_stall_o;

  assign load_ok = (int'(pixel_col_i) < MAX_SIDE) && (int'(pixel_row_i) < MAX_SIDE);
  assign opaque  = spc_opaque(pixel_rgb_i);
  assign waddr   = {SIDE_BITS'(pixel_row_i), SIDE_BITS'(pixel_col_i)};
  assign we_a    = accept && (action_i == ACT_LOAD) && load_ok && !image_sel_i;
  assign we_b    = accept && (action_i == ACT_LOAD) && load_ok && image_sel_i;
  assign start   = accept && (action_i == ACT_TEST);

  assign w_clamp = (int'(size_w_i) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(size_w_i);
  assign h_clamp = (int'(size_h_i) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(size_h_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q[0]  <= '0;
      width_q[1]  <= '0;
      height_q[0] <= '0;
      height_q[1] <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept && (action_i == ACT_SIZE)) begin
        width_q[image_sel_i]  <= w_clamp;
        height_q[image_sel_i] <= h_clamp;
      end
      if (start) begin
        busy_q <= 1'b1;
      end else if (status.done) begin
        busy_q <= 1'b0;
      end
      out_valid_q <= status.done || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (status.done) begin
      collide_q <= status.hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign collide_o   = collide_q;

  spc_mask_mem #(.ADDR_BITS(AB)) u_mask_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (opaque),
    .re_i    (rd_en),
    .raddr_i (rd_addr_a),
    .rdata_o (rd_a)
  );

  spc_mask_mem #(.ADDR_BITS(AB)) u_mask_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (opaque),
    .re_i    (rd_en),
    .raddr_i (rd_addr_b),
    .rdata_o (rd_b)
  );

  spc_walk #(
    .SIDE_BITS  (SIDE_BITS),
    .SW         (SW),
    .COORD_BITS (COORD_BITS)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .active_i    (both_active_i == 2'b11),
    .x1_i        (first_x_i),
    .y1_i        (first_y_i),
    .x2_i        (second_x_i),
    .y2_i        (second_y_i),
    .w1_i        (width_q[0]),
    .h1_i        (height_q[0]),
    .w2_i        (width_q[1]),
    .h2_i        (height_q[1]),
    .rd_en_o     (rd_en),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b),
    .rd_a_i      (rd_a),
    .rd_b_i      (rd_b),
    .status_o    (status)
  );

endmodule
`default_nettype wire

// ----- sim/spc_collide_checker.sv -----
// Checker for the sprite collision block: tracks masks and sizes, predicts and compares collide words.
module spc_collide_checker
  import spc_pkg::*;
#(
  parameter int unsigned MAX_SIDE   = 64,
  parameter int unsigned COORD_BITS = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [ACT_BITS-1:0]          action_i,
  input  logic                         image_sel_i,
  input  logic [PIX_COL_BITS-1:0]      pixel_col_i,
  input  logic [PIX_ROW_BITS-1:0]      pixel_row_i,
  input  logic [RGB_BITS-1:0]          pixel_rgb_i,
  input  logic [SIZE_BITS-1:0]         size_w_i,
  input  logic [SIZE_BITS-1:0]         size_h_i,
  input  logic signed [COORD_BITS-1:0] first_x_i,
  input  logic signed [COORD_BITS-1:0] first_y_i,
  input  logic signed [COORD_BITS-1:0] second_x_i,
  input  logic signed [COORD_BITS-1:0] second_y_i,
  input  logic [1:0]                   both_active_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic                         collide_i,
  output int                           errors_o,
  output int                           pending_o,
  output int                           hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE = MAX_SIDE;

  bit   opaque_a [SIDE*SIDE];
  bit   opaque_b [SIDE*SIDE];
  int   side_w [2];
  int   side_h [2];
  logic collide_q [$];
  logic collide_exp;
  int   pix_idx;

  function automatic int clamp_side(input logic [SIZE_BITS-1:0] v);
    return (int'(v) > SIDE) ? SIDE : int'(v);
  endfunction

  function automatic bit rgb_opaque(input logic [RGB_BITS-1:0] rgb);
    return (rgb != '0) && (rgb != {3{CHAN_MAX}});
  endfunction

  // walk the overlap rectangle in screen space, stop at the first shared opaque pixel
  function automatic logic predict_collide(input int x1, input int y1, input int x2,
                                           input int y2, input logic [1:0] in_use);
    int lx;
    int hx;
    int ly;
    int hy;
    if (in_use != 2'b11) return 1'b0;
    if (x1 > x2 + side_w[1] || x1 + side_w[0] < x2 ||
        y1 > y2 + side_h[1] || y1 + side_h[0] < y2) return 1'b0;
    lx = (x1 > x2) ? x1 : x2;
    hx = (x1 + side_w[0] < x2 + side_w[1]) ? x1 + side_w[0] : x2 + side_w[1];
    ly = (y1 > y2) ? y1 : y2;
    hy = (y1 + side_h[0] < y2 + side_h[1]) ? y1 + side_h[0] : y2 + side_h[1];
    for (int px = lx; px < hx; px++) begin
      for (int py = ly; py < hy; py++) begin
        if (opaque_a[(py - y1) * SIDE + (px - x1)] &&
            opaque_b[(py - y2) * SIDE + (px - x2)]) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] collide check: %s", $realtime, msg);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collide_q.delete();
      side_w    = '{0, 0};
      side_h    = '{0, 0};
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        case (action_i)
          ACT_LOAD: begin
            if (int'(pixel_col_i) < SIDE && int'(pixel_row_i) < SIDE) begin
              pix_idx = int'(pixel_row_i) * SIDE + int'(pixel_col_i);
              if (image_sel_i) opaque_b[pix_idx] = rgb_opaque(pixel_rgb_i);
              else opaque_a[pix_idx] = rgb_opaque(pixel_rgb_i);
            end
          end
          ACT_SIZE: begin
            side_w[image_sel_i] = clamp_side(size_w_i);
            side_h[image_sel_i] = clamp_side(size_h_i);
          end
          ACT_TEST: begin
            collide_q.push_back(predict_collide(int'(first_x_i), int'(first_y_i),
                                                int'(second_x_i), int'(second_y_i),
                                                both_active_i));
          end
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (collide_q.size() == 0) begin
          report_mismatch($sformatf("collide word %b with no test pending", collide_i));
        end else begin
          collide_exp = collide_q.pop_front();
          if (collide_i !== collide_exp)
            report_mismatch($sformatf("collide %b, expected %b", collide_i, collide_exp));
          if (collide_exp) hits_o++;
        end
      end
      pending_o = collide_q.size();
    end
  end

endmodule

// ----- sim/tb_sprite_pixel_collision.sv -----
// Testbench top for sprite_pixel_collision: mask fill, directed and random words, verdict.
module tb_sprite_pixel_collision;
  timeunit 1ns;
  timeprecision 1ps;
  import spc_pkg::*;

  localparam int unsigned MAX_SIDE   = 64;
  localparam int unsigned COORD_BITS = 11;
  localparam logic [ACT_BITS-1:0] ACT_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_WORDS = 64;
  localparam int FILL_SIDE    = 5;
  localparam int COORD_MIN    = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;

  typedef struct {
    logic [ACT_BITS-1:0]          action;
    logic                         sel;
    logic [PIX_COL_BITS-1:0]      col;
    logic [PIX_ROW_BITS-1:0]      row;
    logic [RGB_BITS-1:0]          rgb;
    logic [SIZE_BITS-1:0]         w;
    logic [SIZE_BITS-1:0]         h;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [COORD_BITS-1:0] x2;
    logic signed [COORD_BITS-1:0] y2;
    logic [1:0]                   both_active;
  } spc_word_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [ACT_BITS-1:0]          action;
  logic                         image_sel;
  logic [PIX_COL_BITS-1:0]      pixel_col;
  logic [PIX_ROW_BITS-1:0]      pixel_row;
  logic [RGB_BITS-1:0]          pixel_rgb;
  logic [SIZE_BITS-1:0]         size_w;
  logic [SIZE_BITS-1:0]         size_h;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;
  logic [1:0]                   both_active;
  logic                         out_valid;
  logic                         out_stall;
  logic                         collide;
  int                           errors;
  int                           pending;
  int                           hits;

  int       burst_left = 0;
  int       word_cnt [4] = '{0, 0, 0, 0};
  bit       pressure_go = 1'b0;
  bit       hold_done = 1'b0;
  int       hold_left = 0;
  rx_mode_e rx_mode = RX_FREE;
  int       rx_left = 0;

  sprite_pixel_collision #(
    .MAX_SIDE  (MAX_SIDE),
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .image_sel_i  (image_sel),
    .pixel_col_i  (pixel_col),
    .pixel_row_i  (pixel_row),
    .pixel_rgb_i  (pixel_rgb),
    .size_w_i     (size_w),
    .size_h_i     (size_h),
    .first_x_i    (first_x),
    .first_y_i    (first_y),
    .second_x_i   (second_x),
    .second_y_i   (second_y),
    .both_active_i(both_active),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .collide_o    (collide)
  );

  spc_collide_checker #(
    .MAX_SIDE  (MAX_SIDE),
    .COORD_BITS(COORD_BITS)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .action_i     (action),
    .image_sel_i  (image_sel),
    .pixel_col_i  (pixel_col),
    .pixel_row_i  (pixel_row),
    .pixel_rgb_i  (pixel_rgb),
    .size_w_i     (size_w),
    .size_h_i     (size_h),
    .first_x_i    (first_x),
    .first_y_i    (first_y),
    .second_x_i   (second_x),
    .second_y_i   (second_y),
    .both_active_i(both_active),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .collide_i    (collide),
    .errors_o     (errors),
    .pending_o    (pending),
    .hits_o       (hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: one long hold-off once pressure starts, then a changing stall pattern
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_go && !hold_done && hold_left == 0) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
        if (hold_left == 0) hold_done = 1'b1;
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 3));
          rx_left = $urandom_range(8, 64);
        end
        rx_left--;
        case (rx_mode)
          RX_FREE:   out_stall = 1'b0;
          RX_LIGHT:  out_stall = ($urandom_range(0, 3) == 0);
          RX_HEAVY:  out_stall = ($urandom_range(0, 9) < 7);
          RX_TOGGLE: out_stall = ~out_stall;
          default:   out_stall = 1'b0;
        endcase
      end
    end
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d collide words outstanding", pending);
    $display("tb_sprite_pixel_collision: done, errors");
    $finish;
  end

  function automatic spc_word_t rand_word(input logic [ACT_BITS-1:0] a);
    spc_word_t w;
    w.action      = a;
    w.sel         = 1'($urandom);
    w.col         = PIX_COL_BITS'($urandom);
    w.row         = PIX_ROW_BITS'($urandom);
    w.rgb         = RGB_BITS'($urandom);
    w.w           = SIZE_BITS'($urandom);
    w.h           = SIZE_BITS'($urandom);
    w.x1          = COORD_BITS'($urandom);
    w.y1          = COORD_BITS'($urandom);
    w.x2          = COORD_BITS'($urandom);
    w.y2          = COORD_BITS'($urandom);
    w.both_active = 2'($urandom);
    return w;
  endfunction

  function automatic logic [RGB_BITS-1:0] pick_rgb(input int opaque_pct);
    logic [RGB_BITS-1:0] c;
    if ($urandom_range(0, 99) < opaque_pct) begin
      do c = RGB_BITS'($urandom); while (c == '0 || c == '1);
      return c;
    end
    return $urandom_range(0, 1) ? {3{CHAN_MAX}} : '0;
  endfunction

  function automatic int clamp_coord(input int v);
    return (v > COORD_MAX) ? COORD_MAX : (v < COORD_MIN) ? COORD_MIN : v;
  endfunction

  // sizes stay inside the loaded corner so every walked pixel has been written
  function automatic int pick_side();
    return int'($urandom_range(0, FILL_SIDE));
  endfunction

  // sender pacing: bursts of words with random gaps between them
  task automatic send_word(input spc_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_valid    = 1'b1;
    action      = w.action;
    image_sel   = w.sel;
    pixel_col   = w.col;
    pixel_row   = w.row;
    pixel_rgb   = w.rgb;
    size_w      = w.w;
    size_h      = w.h;
    first_x     = w.x1;
    first_y     = w.y1;
    second_x    = w.x2;
    second_y    = w.y2;
    both_active = w.both_active;
    do @(posedge clk); while (in_stall);
    word_cnt[w.action]++;
  endtask

  task automatic load_pix(input logic sel, input int col, input int row,
                          input logic [RGB_BITS-1:0] rgb);
    spc_word_t w;
    w     = rand_word(ACT_LOAD);
    w.sel = sel;
    w.col = PIX_COL_BITS'(col);
    w.row = PIX_ROW_BITS'(row);
    w.rgb = rgb;
    send_word(w);
  endtask

  task automatic set_size(input logic sel, input int sw, input int sh);
    spc_word_t w;
    w     = rand_word(ACT_SIZE);
    w.sel = sel;
    w.w   = SIZE_BITS'(sw);
    w.h   = SIZE_BITS'(sh);
    send_word(w);
  endtask

  task automatic run_test(input int x1, input int y1, input int x2, input int y2,
                          input logic [1:0] in_use);
    spc_word_t w;
    w             = rand_word(ACT_TEST);
    w.x1          = COORD_BITS'(x1);
    w.y1          = COORD_BITS'(y1);
    w.x2          = COORD_BITS'(x2);
    w.y2          = COORD_BITS'(y2);
    w.both_active = in_use;
    send_word(w);
  endtask

  initial begin
    int r;
    int x1;
    int y1;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    action      = ACT_LOAD;
    image_sel   = 1'b0;
    pixel_col   = '0;
    pixel_row   = '0;
    pixel_rgb   = '0;
    size_w      = '0;
    size_h      = '0;
    first_x     = '0;
    first_y     = '0;
    second_x    = '0;
    second_y    = '0;
    both_active = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // the top-left corner of both masks is written before any test can read it
    for (int img = 0; img < 2; img++)
      for (int row = 0; row < FILL_SIDE; row++)
        for (int col = 0; col < FILL_SIDE; col++)
          load_pix(1'(img), col, row, pick_rgb(30));

    load_pix(1'b0, 0, 0, 24'h000001);
    load_pix(1'b1, 0, 0, 24'hFFFFFE);
    load_pix(1'b0, 63, 63, 24'hFF0000);
    load_pix(1'b1, 63, 63, 24'h00FF00);
    load_pix(1'b0, 1, 0, {3{CHAN_MAX}});
    load_pix(1'b1, 1, 0, 24'h000000);
    run_test(0, 0, 0, 0, 2'b11);            // both images still zero-sized
    set_size(1'b0, 1, 1);
    set_size(1'b1, 1, 1);
    run_test(10, 10, 10, 10, 2'b11);
    run_test(10, 10, 10, 10, 2'b01);
    run_test(10, 10, 10, 10, 2'b10);
    run_test(10, 10, 10, 10, 2'b00);
    run_test(10, 10, 11, 10, 2'b11);        // edges touch in x
    run_test(10, 10, 10, 9, 2'b11);         // edges touch in y
    set_size(1'b0, 2, 1);
    set_size(1'b1, 2, 1);
    run_test(20, 5, 21, 5, 2'b11);          // overlap only on transparent pixel
    set_size(1'b1, 0, 5);
    run_test(10, 10, 10, 10, 2'b11);
    set_size(1'b0, 127, 127);               // saturates
    set_size(1'b1, 65, 64);
    run_test(COORD_MIN, COORD_MIN, COORD_MIN + 63, COORD_MIN + 63, 2'b11);
    run_test(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 2'b11);
    run_test(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 2'b11);
    send_word(rand_word(ACT_UNUSED));
    set_size(1'b0, FILL_SIDE, FILL_SIDE);
    set_size(1'b1, FILL_SIDE, FILL_SIDE);

    pressure_go = 1'b1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        load_pix(1'($urandom), $urandom_range(0, FILL_SIDE - 1),
                 $urandom_range(0, FILL_SIDE - 1),
                 $urandom_range(0, 1) ? pick_rgb(50) : RGB_BITS'($urandom));
      end else if (r < 40) begin
        set_size(1'($urandom), pick_side(), pick_side());
      end else if (r < 95) begin
        x1 = int'($urandom_range(0, 2047)) + COORD_MIN;
        y1 = int'($urandom_range(0, 2047)) + COORD_MIN;
        if ($urandom_range(0, 4) != 0)
          run_test(x1, y1,
                   clamp_coord(x1 + int'($urandom_range(0, 2 * FILL_SIDE)) - FILL_SIDE),
                   clamp_coord(y1 + int'($urandom_range(0, 2 * FILL_SIDE)) - FILL_SIDE),
                   ($urandom_range(0, 5) != 0) ? 2'b11 : 2'($urandom_range(0, 2)));
        else
          run_test(x1, y1, int'($urandom_range(0, 2047)) + COORD_MIN,
                   int'($urandom_range(0, 2047)) + COORD_MIN, 2'($urandom));
      end else begin
        send_word(rand_word(ACT_UNUSED));
      end
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);

    $display("covered %0d loads (%0dx%0d corner of both masks), %0d size words, %0d tests, %0d ignored",
             word_cnt[ACT_LOAD], FILL_SIDE, FILL_SIDE, word_cnt[ACT_SIZE],
             word_cnt[ACT_TEST], word_cnt[ACT_UNUSED]);
    $display("%0d tests hit; receiver held off %0d cycles once; %0d mismatches",
             hits, HOLD_CYCLES, errors);
    if (errors == 0)
      $display("tb_sprite_pixel_collision: done, clean");
    else
      $display("tb_sprite_pixel_collision: done, errors");
    $finish;
  end

endmodule

// ----- sprite_pixel_collision.f -----
+incdir+rtl/core
rtl/core/spc_pkg.sv
rtl/core/spc_mask_mem.sv
rtl/core/spc_walk.sv
rtl/core/sprite_pixel_collision.sv
sim/spc_collide_checker.sv
sim/tb_sprite_pixel_collision.sv
